/* sv/t2i_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// t2i_pkg
// Shared types, constants and character helpers for the text to int64 parser.
// ----------------------------------------------------------------------------
package t2i_pkg;

  localparam int unsigned MAX_STRING_LEN = 255;
  localparam int unsigned POS_W          = $clog2(MAX_STRING_LEN + 1);

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned END_W    = 8;
  localparam int unsigned PROD_W   = VALUE_W + RADIX_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = RADIX_W;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_BIN    = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd63;

  localparam logic [VALUE_W-1:0] ALL_ONES       = {VALUE_W{1'b1}};
  localparam logic [VALUE_W-1:0] SIGNED_MAX     = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SIGNED_MIN_MAG = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  // classified character as it travels from front to back
  typedef struct packed {
    logic               is_nul;
    logic               is_space;
    logic               is_minus;
    logic               is_plus;
    logic               is_zero;
    logic               is_x;
    logic               is_b;
    logic [RADIX_W-1:0] digit;
    logic               in_range;
    logic [POS_W-1:0]   pos;
    logic               last;
  } item_t;

  function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] ch);
    logic [RADIX_W-1:0] d;
    d = DIGIT_NONE;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = RADIX_W'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      d = RADIX_W'(ch - 8'h61 + 8'd10);
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      d = RADIX_W'(ch - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_c_space(input logic [CHAR_W-1:0] ch);
    return (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0d);
  endfunction

endpackage
`default_nettype wire

/* sv/t2i_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// t2i_front
// Accepts characters, tracks the position inside the string and classifies
// each character for the parse engine.
// ----------------------------------------------------------------------------
module t2i_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [t2i_pkg::CHAR_W-1:0]     in_char_i,
  input  wire logic                           in_last_i,
  input  wire logic                           push_ready_i,
  output logic                                push_o,
  output t2i_pkg::item_t                      push_item_o
);

  logic [t2i_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      in_range;
  logic                      accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;
  assign in_range   = pos_q < t2i_pkg::POS_W'(t2i_pkg::MAX_STRING_LEN);

  always_comb begin
    push_item_o.is_nul   = in_char_i == 8'h00;
    push_item_o.is_space = t2i_pkg::is_c_space(in_char_i);
    push_item_o.is_minus = in_char_i == 8'h2d;
    push_item_o.is_plus  = in_char_i == 8'h2b;
    push_item_o.is_zero  = in_char_i == 8'h30;
    push_item_o.is_x     = (in_char_i == 8'h78) || (in_char_i == 8'h58);
    push_item_o.is_b     = (in_char_i == 8'h62) || (in_char_i == 8'h42);
    push_item_o.digit    = t2i_pkg::digit_value(in_char_i);
    push_item_o.in_range = in_range;
    push_item_o.pos      = pos_q + t2i_pkg::POS_W'(1);
    push_item_o.last     = in_last_i;
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (in_last_i) begin
        pos_d = '0;
      end else if (in_range) begin
        pos_d = pos_q + t2i_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

/* sv/t2i_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// t2i_fifo
// Short queue of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module t2i_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire t2i_pkg::item_t push_item_i,
  output logic                push_ready_o,
  input  wire logic           pop_i,
  output t2i_pkg::item_t      pop_item_o,
  output logic                pop_valid_o
);

  t2i_pkg::item_t                 mem_q [t2i_pkg::FIFO_DEPTH];
  logic [t2i_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [t2i_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic                           do_push, do_pop;

  assign push_ready_o = count_q != t2i_pkg::FIFO_CNT_W'(t2i_pkg::FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  function automatic logic [t2i_pkg::FIFO_PTR_W-1:0] ptr_next(
    input logic [t2i_pkg::FIFO_PTR_W-1:0] p
  );
    logic [t2i_pkg::FIFO_PTR_W-1:0] n;
    if (p == t2i_pkg::FIFO_PTR_W'(t2i_pkg::FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + t2i_pkg::FIFO_PTR_W'(1);
    end
    return n;
  endfunction

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + t2i_pkg::FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - t2i_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

/* sv/t2i_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// t2i_back
// Parse engine: phase machine, multiply-add accumulator with wrap detection,
// configuration registers and the result register with final saturation.
// ----------------------------------------------------------------------------
module t2i_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [t2i_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [t2i_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire t2i_pkg::item_t                   pop_item_i,
  input  wire logic                             pop_valid_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [t2i_pkg::VALUE_W-1:0]           out_value_o,
  output logic                                  out_ovf_o,
  output logic [t2i_pkg::END_W-1:0]             out_end_o
);

  // configuration
  logic [t2i_pkg::RADIX_W-1:0] radix_q;
  logic                        signed_mode_q;

  // parse state
  t2i_pkg::phase_e             phase_q, phase_d;
  logic [t2i_pkg::VALUE_W-1:0] acc_q, acc_d;
  logic                        ovf_q, ovf_d;
  logic                        neg_q, neg_d;
  logic [t2i_pkg::RADIX_W-1:0] base_q, base_d;
  logic [t2i_pkg::POS_W-1:0]   conv_end_q, conv_end_d;

  // result register
  logic                        res_valid_q;
  logic [t2i_pkg::VALUE_W-1:0] res_acc_q;
  logic                        res_ovf_q;
  logic                        res_neg_q;
  logic                        res_sgn_q;
  logic [t2i_pkg::POS_W-1:0]   res_end_q;

  logic                        out_free;
  logic                        step;
  logic                        start;
  logic                        try_en;
  logic [t2i_pkg::RADIX_W-1:0] try_base;
  logic [t2i_pkg::PROD_W-1:0]  mac;
  logic                        wrap;
  logic                        digit_ok;
  logic                        radix_ok;

  assign out_free = !res_valid_q || out_ready_i;
  assign pop_o    = pop_valid_i && (!pop_item_i.last || out_free);
  assign step     = pop_o;
  assign radix_ok = (radix_q >= t2i_pkg::RADIX_MIN) && (radix_q <= t2i_pkg::RADIX_MAX);

  // one shared multiply-add serves every digit attempt
  assign mac  = t2i_pkg::PROD_W'(acc_q) * t2i_pkg::PROD_W'(try_base)
              + t2i_pkg::PROD_W'(pop_item_i.digit);
  assign wrap = |mac[t2i_pkg::PROD_W-1:t2i_pkg::VALUE_W];
  assign digit_ok = (try_base >= t2i_pkg::RADIX_MIN) && (pop_item_i.digit < try_base);

  always_comb begin
    start    = 1'b0;
    try_en   = 1'b0;
    try_base = base_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    neg_d      = neg_q;
    base_d     = base_q;
    conv_end_d = conv_end_q;

    if (!pop_item_i.in_range || pop_item_i.is_nul) begin
      phase_d = t2i_pkg::PH_DONE;
    end else begin
      case (phase_q)
        t2i_pkg::PH_SPACE: begin
          if (pop_item_i.is_space) begin
            phase_d = phase_q;
          end else if (pop_item_i.is_minus) begin
            neg_d   = 1'b1;
            phase_d = t2i_pkg::PH_SIGNED;
          end else if (pop_item_i.is_plus) begin
            phase_d = t2i_pkg::PH_SIGNED;
          end else begin
            start = 1'b1;
          end
        end
        t2i_pkg::PH_SIGNED: begin
          start = 1'b1;
        end
        t2i_pkg::PH_ZERO: begin
          if (pop_item_i.is_x) begin
            base_d  = t2i_pkg::BASE_HEX;
            phase_d = t2i_pkg::PH_PREFIX;
          end else if (pop_item_i.is_b) begin
            base_d  = t2i_pkg::BASE_BIN;
            phase_d = t2i_pkg::PH_PREFIX;
          end else begin
            try_en   = 1'b1;
            try_base = t2i_pkg::BASE_OCT;
          end
        end
        t2i_pkg::PH_PREFIX, t2i_pkg::PH_DIGITS: begin
          try_en   = 1'b1;
          try_base = base_q;
        end
        t2i_pkg::PH_DONE: begin
          phase_d = phase_q;
        end
        default: begin
          phase_d = t2i_pkg::PH_DONE;
        end
      endcase
    end

    if (start) begin
      if (radix_q == t2i_pkg::RADIX_AUTO) begin
        if (pop_item_i.is_zero) begin
          conv_end_d = pop_item_i.pos;
          phase_d    = t2i_pkg::PH_ZERO;
        end else begin
          try_en   = 1'b1;
          try_base = t2i_pkg::BASE_DEC;
        end
      end else if (radix_ok) begin
        try_en   = 1'b1;
        try_base = radix_q;
      end else begin
        phase_d = t2i_pkg::PH_DONE;
      end
    end

    if (try_en) begin
      base_d = try_base;
      if (!digit_ok) begin
        phase_d = t2i_pkg::PH_DONE;
      end else begin
        if (!ovf_q) begin
          if (wrap) begin
            ovf_d = 1'b1;
            acc_d = t2i_pkg::ALL_ONES;
          end else begin
            acc_d = mac[t2i_pkg::VALUE_W-1:0];
          end
        end
        conv_end_d = pop_item_i.pos;
        phase_d    = t2i_pkg::PH_DIGITS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= t2i_pkg::RADIX_RESET;
      signed_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        t2i_pkg::REG_RADIX:       radix_q       <= cfg_wdata_i;
        t2i_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_wdata_i[0];
        default: begin
          radix_q <= radix_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= t2i_pkg::PH_SPACE;
      acc_q      <= '0;
      ovf_q      <= 1'b0;
      neg_q      <= 1'b0;
      base_q     <= '0;
      conv_end_q <= '0;
    end else if (step) begin
      if (pop_item_i.last) begin
        phase_q    <= t2i_pkg::PH_SPACE;
        acc_q      <= '0;
        ovf_q      <= 1'b0;
        neg_q      <= 1'b0;
        base_q     <= '0;
        conv_end_q <= '0;
      end else begin
        phase_q    <= phase_d;
        acc_q      <= acc_d;
        ovf_q      <= ovf_d;
        neg_q      <= neg_d;
        base_q     <= base_d;
        conv_end_q <= conv_end_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step && pop_item_i.last) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && pop_item_i.last) begin
      res_acc_q <= acc_d;
      res_ovf_q <= ovf_d;
      res_neg_q <= neg_d;
      res_sgn_q <= signed_mode_q;
      res_end_q <= conv_end_d;
    end
  end

  // saturation and sign applied on the way out of the result register
  logic [t2i_pkg::VALUE_W-1:0] limit;
  logic [t2i_pkg::VALUE_W-1:0] mag;
  logic                        sat_ovf;

  always_comb begin
    if (res_sgn_q) begin
      limit = res_neg_q ? t2i_pkg::SIGNED_MIN_MAG : t2i_pkg::SIGNED_MAX;
    end else begin
      limit = t2i_pkg::ALL_ONES;
    end
    mag     = res_acc_q;
    sat_ovf = res_ovf_q;
    if (res_acc_q > limit) begin
      mag     = limit;
      sat_ovf = 1'b1;
    end
    out_value_o = '0;
    out_ovf_o   = 1'b0;
    out_end_o   = '0;
    if (res_end_q != '0) begin
      if (!res_neg_q) begin
        out_value_o = mag;
      end else if (!res_sgn_q && sat_ovf) begin
        out_value_o = t2i_pkg::ALL_ONES;
      end else begin
        out_value_o = '0 - mag;
      end
      out_ovf_o = sat_ovf;
      out_end_o = t2i_pkg::END_W'(res_end_q);
    end
  end

  assign out_valid_o = res_valid_q;

`ifndef SYNTHESIS
  a_acc_clear_before_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == t2i_pkg::PH_SPACE || phase_q == t2i_pkg::PH_SIGNED) |-> acc_q == '0
  ) else $error("accumulator nonzero before the number starts");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> acc_q == t2i_pkg::ALL_ONES
  ) else $error("overflow flag set without saturated accumulator");

  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && pop_item_i.last) |=> (phase_q == t2i_pkg::PH_SPACE && conv_end_q == '0)
  ) else $error("parse state not cleared after the last character");

  a_no_pop_last_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_ready_i && pop_valid_i && pop_item_i.last) |-> !pop_o
  ) else $error("last character taken while result register is blocked");
`endif

endmodule
`default_nettype wire

/* sv/text_to_int64_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_int64_parser_top
// Streaming string to 64-bit integer converter, strtoll / strtoull style.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while the queue has room, with one result
// per string on the character marked tlast. The rate is set by the back end's
// single 64x6 multiply-add per character, which serves each character taken.
// A two-entry queue separates the character front end from the parse engine,
// and a result register holds the finished value, so characters of the next
// string keep flowing while a result waits, until that string's last character
// reaches the parse engine and the queue fills; a string's last character passes
// through the queue, then its result is offered from the result register. Leading
// whitespace and one sign are skipped, radix 0 detects a 0x, 0b or 0 prefix,
// overflow saturates to the limit of the selected mode.
// Registers (write only): index 0 radix (2..36, 0 = auto), index 1 signed_mode.
// Write them only while no string is in flight.
module text_to_int64_parser_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [t2i_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [t2i_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // character stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [t2i_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [7:0] char_code
  input  wire logic                               s_axis_tlast,
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [t2i_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,   // [63:0] value_bits, [71:64] end_index
  output logic                                    m_axis_tuser    // [0] overflowed
);

  t2i_pkg::item_t                 push_item;
  t2i_pkg::item_t                 pop_item;
  logic                           push;
  logic                           push_ready;
  logic                           pop;
  logic                           pop_valid;
  logic [t2i_pkg::VALUE_W-1:0]    out_value;
  logic [t2i_pkg::END_W-1:0]      out_end;

  t2i_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata[t2i_pkg::CHAR_W-1:0]),
    .in_last_i    (s_axis_tlast),
    .push_ready_i (push_ready),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  t2i_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid)
  );

  t2i_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pop_item_i   (pop_item),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_ovf_o    (m_axis_tuser),
    .out_end_o    (out_end)
  );

  assign m_axis_tdata = {out_end, out_value};

endmodule
`default_nettype wire

/* sim/text_to_int64_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_int64_parser_top_tb
// Self-checking bench for the streaming text to int64 converter. Strings are
// pushed one character per transaction under several radix / signedness
// settings, with random idling on both streams. A scoreboard tracks the parse
// state per character and compares every returned value, overflow flag and end
// index with its own prediction.
// ----------------------------------------------------------------------------
module text_to_int64_parser_top_tb;
  import t2i_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ovf;
    logic [END_W-1:0]   end_pos;
  } conv_result_t;

  class conversion_scoreboard;
    logic [RADIX_W-1:0] radix;
    bit                 signed_mode;
    phase_e             phase;
    logic [VALUE_W-1:0] acc;
    bit                 ovf_flag;
    bit                 neg_flag;
    logic [RADIX_W-1:0] base;
    int unsigned        pos;
    int unsigned        conv_end;
    conv_result_t       pending_values[$];
    int unsigned        errors;

    function new();
      radix       = RADIX_RESET;
      signed_mode = 1'b1;
      errors      = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase    = PH_SPACE;
      acc      = '0;
      ovf_flag = 1'b0;
      neg_flag = 1'b0;
      base     = '0;
      pos      = 0;
      conv_end = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_RADIX) begin
        radix = data;
      end else begin
        signed_mode = data[0];
      end
    endfunction

    function int unsigned digit_of(byte unsigned ch);
      if (ch >= "0" && ch <= "9") return ch - 8'h30;
      if (ch >= "a" && ch <= "z") return ch - 8'h61 + 10;
      if (ch >= "A" && ch <= "Z") return ch - 8'h41 + 10;
      return DIGIT_NONE;
    endfunction

    function void take_digit(byte unsigned ch);
      int unsigned        d;
      logic [VALUE_W-1:0] b;
      d = digit_of(ch);
      if (base < RADIX_MIN || d >= base) begin
        phase = PH_DONE;
        return;
      end
      // saturated digits still move the end index
      if (!ovf_flag) begin
        b = VALUE_W'(base);
        if (acc > (ALL_ONES - VALUE_W'(d)) / b) begin
          ovf_flag = 1'b1;
          acc      = ALL_ONES;
        end else begin
          acc = acc * b + VALUE_W'(d);
        end
      end
      conv_end = pos;
      phase    = PH_DIGITS;
    endfunction

    function void begin_number(byte unsigned ch);
      if (radix == RADIX_AUTO) begin
        if (ch == "0") begin
          conv_end = pos;
          phase    = PH_ZERO;
        end else begin
          base = BASE_DEC;
          take_digit(ch);
        end
      end else if (radix >= RADIX_MIN && radix <= RADIX_MAX) begin
        base = radix;
        take_digit(ch);
      end else begin
        phase = PH_DONE;
      end
    endfunction

    function void step_char(byte unsigned ch);
      if (ch == 8'h00) begin
        phase = PH_DONE;
        return;
      end
      case (phase)
        PH_SPACE: begin
          if (!(ch == " " || (ch >= 8'h09 && ch <= 8'h0d))) begin
            if (ch == "-") begin
              neg_flag = 1'b1;
              phase    = PH_SIGNED;
            end else if (ch == "+") begin
              phase = PH_SIGNED;
            end else begin
              begin_number(ch);
            end
          end
        end
        PH_SIGNED: begin_number(ch);
        PH_ZERO: begin
          if (ch == "x" || ch == "X") begin
            base  = BASE_HEX;
            phase = PH_PREFIX;
          end else if (ch == "b" || ch == "B") begin
            base  = BASE_BIN;
            phase = PH_PREFIX;
          end else begin
            base = BASE_OCT;
            take_digit(ch);
          end
        end
        PH_PREFIX, PH_DIGITS: take_digit(ch);
        default: ;
      endcase
    endfunction

    function void take_char(byte unsigned ch, bit last);
      conv_result_t       r;
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] limit;
      // characters past the length limit end the parse
      if (pos < MAX_STRING_LEN) begin
        pos++;
        step_char(ch);
      end else begin
        phase = PH_DONE;
      end
      if (!last) return;
      r = '0;
      if (conv_end != 0) begin
        mag   = acc;
        r.ovf = ovf_flag;
        if (signed_mode) limit = neg_flag ? SIGNED_MIN_MAG : SIGNED_MAX;
        else limit = ALL_ONES;
        if (mag > limit) begin
          mag   = limit;
          r.ovf = 1'b1;
        end
        if (!neg_flag) r.value = mag;
        else if (!signed_mode && r.ovf) r.value = ALL_ONES;
        else r.value = '0 - mag;
        r.end_pos = END_W'(conv_end);
      end
      pending_values.push_back(r);
      clear_parse();
    endfunction

    function void check_value(logic [VALUE_W-1:0] value, logic ovf, logic [END_W-1:0] end_pos);
      conv_result_t r;
      if (pending_values.size() == 0) begin
        $error("unexpected result: value_bits %h overflowed %b end_index %0d",
               value, ovf, end_pos);
        errors++;
        return;
      end
      r = pending_values.pop_front();
      if (value !== r.value) begin
        $error("value_bits: expected %h, actual %h", r.value, value);
        errors++;
      end
      if (ovf !== r.ovf) begin
        $error("overflowed: expected %b, actual %b", r.ovf, ovf);
        errors++;
      end
      if (end_pos !== r.end_pos) begin
        $error("end_index: expected %0d, actual %0d", r.end_pos, end_pos);
        errors++;
      end
    endfunction
  endclass

  localparam int RX_HOLD_CYCLES = 80;
  localparam int SEGMENTS       = 12;
  localparam int SEG_CHARS      = 55;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  conversion_scoreboard sb;
  int unsigned          tx_idle_pct = 37;
  int unsigned          rx_idle_pct = 79;
  int unsigned          rx_hold_reqs = 0;
  int unsigned          rx_hold_done = 0;
  logic [RADIX_W-1:0]   cur_radix = RADIX_RESET;

  logic [RADIX_W-1:0] seg_radix [SEGMENTS] = '{6'd10, 6'd0, 6'd16, 6'd2, 6'd36, 6'd0,
                                               6'd8, 6'd1, 6'd63, 6'd37, 6'd0, 6'd36};
  bit                 seg_signed[SEGMENTS] = '{1, 1, 0, 1, 0, 0, 1, 1, 0, 1, 1, 1};

  text_to_int64_parser_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [63:0] value_bits, [71:64] end_index
    .m_axis_tuser  (m_axis_tuser)    // [0] overflowed
  );

  always #5 clk_i = ~clk_i;

  // result check first, then the character of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_value(m_axis_tdata[63:0], m_axis_tuser, m_axis_tdata[71:64]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.take_char(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_reqs != rx_hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk_i);
        rx_hold_done++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // call at a falling edge; leaves tvalid high after the transaction
  task automatic send_char(input byte unsigned ch, input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input byte unsigned s[$]);
    int i;
    for (i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string s);
    byte unsigned q[$];
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_values.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    if (idx == REG_RADIX) cur_radix = data;
  endtask

  function automatic byte unsigned digit_char(int unsigned v);
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 10;
  endfunction

  // mostly well-formed numbers, some noise, now and then an over-long string
  function automatic void make_string(input logic [RADIX_W-1:0] radix, ref byte unsigned s[$]);
    byte unsigned ws[6] = '{8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20};
    int unsigned  kind;
    int unsigned  n;
    int unsigned  base;
    s.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 8);
      repeat (n) s.push_back(8'($urandom_range(255)));
      return;
    end
    if (kind < 12) begin
      n = $urandom_range(250, 300);
      repeat (n) s.push_back(digit_char($urandom_range(9)));
      return;
    end
    if ($urandom_range(1)) repeat ($urandom_range(1, 3)) s.push_back(ws[$urandom_range(5)]);
    case ($urandom_range(3))
      0: s.push_back("-");
      1: s.push_back("+");
      default: ;
    endcase
    base = (radix >= RADIX_MIN && radix <= RADIX_MAX) ? radix : BASE_DEC;
    if (radix == RADIX_AUTO) begin
      case ($urandom_range(4))
        0: begin
          s.push_back("0");
          s.push_back($urandom_range(1) ? "x" : "X");
          base = BASE_HEX;
        end
        1: begin
          s.push_back("0");
          s.push_back($urandom_range(1) ? "b" : "B");
          base = BASE_BIN;
        end
        2: begin
          s.push_back("0");
          base = BASE_OCT;
        end
        default: ;
      endcase
    end
    n = ($urandom_range(7) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 20);
    repeat (n) s.push_back(digit_char($urandom_range(base - 1)));
    repeat ($urandom_range(0, 2)) s.push_back(8'($urandom_range(255)));
    if (s.size() == 0) s.push_back(8'($urandom_range(255)));
  endfunction

  initial begin
    byte unsigned str_q[$];
    int           seg;
    int unsigned  chars;
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: decimal, signed
    send_text("  \t\n-123");
    send_text("+9223372036854775807");
    send_text("-9223372036854775808");
    send_text("9223372036854775808");
    send_text("-9223372036854775809");
    send_text("18446744073709551616");
    send_text("   -");
    send_text("12a");
    // zero byte ends the parse
    str_q = '{8'h31, 8'h32, 8'h00, 8'h20, 8'h33, 8'h34};
    send_bytes(str_q);
    str_q = '{8'hff};
    send_bytes(str_q);

    // prefix detection
    write_reg(REG_RADIX, RADIX_AUTO);
    send_text("0x1F");
    send_text("0X");
    send_text("0b101");
    send_text("0B2");
    send_text("0777");
    send_text("089");
    send_text("-0x8000000000000000");
    send_text("0xffffffffffffffffff");

    write_reg(REG_SIGNED_MODE, CFG_DATA_W'(1'b0));
    send_text("-1");
    send_text("18446744073709551615");
    send_text("-0x10000000000000000");
    send_text("-0");

    write_reg(REG_RADIX, 6'd36);
    send_text("zZz9");
    write_reg(REG_RADIX, 6'd1);
    send_text("1");
    write_reg(REG_RADIX, 6'd63);
    send_text("z");

    for (seg = 0; seg < SEGMENTS; seg++) begin
      write_reg(REG_RADIX, seg_radix[seg]);
      write_reg(REG_SIGNED_MODE, CFG_DATA_W'(seg_signed[seg]));
      if (seg < 4) begin
        tx_idle_pct = 37;
        rx_idle_pct = 79;
      end else if (seg < 8) begin
        tx_idle_pct = 79;
        rx_idle_pct = 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // fill the block while the result side holds off
      if (seg == 1 || seg == 9) rx_hold_reqs++;
      chars = 0;
      while (chars < SEG_CHARS) begin
        make_string(cur_radix, str_q);
        send_bytes(str_q);
        chars += str_q.size();
        if (seg == 5 && chars >= SEG_CHARS / 2 && chars < SEG_CHARS / 2 + str_q.size()) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_values.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/t2i_pkg.sv
sv/t2i_front.sv
sv/t2i_fifo.sv
sv/t2i_back.sv
sv/text_to_int64_parser_top.sv
sim/text_to_int64_parser_top_tb.sv
